// ===== rtl/core/msc_pkg.sv =====
// Shared types and constants for the MSI snooping cache controller.
package msc_pkg;

    // Fixed field widths of the request, response and line state.
    localparam int CMD_W     = 3;
    localparam int ADDR_W    = 32;
    localparam int STATE_W   = 2;
    localparam int BUS_REQ_W = 2;

    // Widest way index the way scan reports (up to sixteen ways).
    localparam int WAY_IDX_W = 4;

    // Request command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_PROC_RD  = 3'd0,
        CMD_PROC_WR  = 3'd1,
        CMD_SNP_RD   = 3'd2,
        CMD_SNP_RDX  = 3'd3,
        CMD_SNP_UPGR = 3'd4
    } cmd_t;

    // MSI line states.
    typedef enum logic [STATE_W-1:0] {
        ST_INVALID  = 2'd0,
        ST_SHARED   = 2'd1,
        ST_MODIFIED = 2'd2
    } line_state_t;

    // Bus transactions requested by processor accesses.
    typedef enum logic [BUS_REQ_W-1:0] {
        REQ_NONE    = 2'd0,
        REQ_BUSRD   = 2'd1,
        REQ_BUSRDX  = 2'd2,
        REQ_BUSUPGR = 2'd3
    } bus_req_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        FSM_CLEAR  = 2'd0,
        FSM_IDLE   = 2'd1,
        FSM_SCAN   = 2'd2,
        FSM_UPDATE = 2'd3
    } fsm_state_t;

    // Outcome of the way scan over one set.
    typedef struct packed {
        logic                 found;
        logic [WAY_IDX_W-1:0] hit_way;
        logic                 free_found;
        logic [WAY_IDX_W-1:0] free_way;
        logic [WAY_IDX_W-1:0] lru_way;
    } scan_t;

    // One response.
    typedef struct packed {
        bus_req_t bus_request;
        logic     hit;
        logic     write_back;
        logic     flush_out;
        logic     invalidated;
        logic     intervention;
    } rsp_t;

endpackage

// ===== rtl/core/msc_if.sv =====
// Handshake interfaces for the request, response and configuration channels.
interface msc_req_if import msc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;

    modport source (output valid, cmd, addr, input ready);
    modport sink   (input valid, cmd, addr, output ready);
endinterface

interface msc_rsp_if import msc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BUS_REQ_W-1:0] bus_request;
    logic                 hit;
    logic                 write_back;
    logic                 flush_out;
    logic                 invalidated;
    logic                 intervention;

    modport source (output valid, bus_request, hit, write_back, flush_out, invalidated,
                    intervention, input ready);
    modport sink   (input valid, bus_request, hit, write_back, flush_out, invalidated,
                    intervention, output ready);
endinterface

interface msc_cfg_if ();
    logic valid;
    logic ready;
    logic use_upgrade;

    modport source (output valid, use_upgrade, input ready);
    modport sink   (input valid, use_upgrade, output ready);
endinterface

// ===== rtl/core/msc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module msc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/msc_way_unit.sv =====
// Shared way comparator: checks one way per cycle for tag match, free way and LRU victim.
module msc_way_unit import msc_pkg::*; #(
    parameter int NUM_WAYS = 4,
    parameter int TAG_W    = 20,
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               step,
    input  logic [WAY_W-1:0]   way,
    input  logic [STATE_W-1:0] way_state,
    input  logic [TAG_W-1:0]   way_tag,
    input  logic [WAY_W-1:0]   way_rank,
    input  logic [TAG_W-1:0]   lookup_tag,
    output scan_t              scan
);

    logic             found_reg, found_next;
    logic [WAY_W-1:0] hit_way_reg, hit_way_next;
    logic             free_found_reg, free_found_next;
    logic [WAY_W-1:0] free_way_reg, free_way_next;
    logic [WAY_W-1:0] lru_way_reg, lru_way_next;
    logic             way_valid;

    assign way_valid = (way_state != ST_INVALID);

    // Tracker update: first match, first invalid way, and the way ranked least recent.
    always_comb
    begin
        found_next      = found_reg;
        hit_way_next    = hit_way_reg;
        free_found_next = free_found_reg;
        free_way_next   = free_way_reg;
        lru_way_next    = lru_way_reg;
        if (start)
        begin
            found_next      = 1'b0;
            hit_way_next    = '0;
            free_found_next = 1'b0;
            free_way_next   = '0;
            lru_way_next    = '0;
        end
        else if (step)
        begin
            if (way_valid && (way_tag == lookup_tag) && !found_reg)
            begin
                found_next   = 1'b1;
                hit_way_next = way;
            end
            if (!way_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_way_next   = way;
            end
            if (way_rank == WAY_W'(NUM_WAYS - 1))
            begin
                lru_way_next = way;
            end
        end
    end

    // Tracker registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            hit_way_reg    <= '0;
            free_found_reg <= 1'b0;
            free_way_reg   <= '0;
            lru_way_reg    <= '0;
        end
        else
        begin
            found_reg      <= found_next;
            hit_way_reg    <= hit_way_next;
            free_found_reg <= free_found_next;
            free_way_reg   <= free_way_next;
            lru_way_reg    <= lru_way_next;
        end
    end

    assign scan.found      = found_reg;
    assign scan.hit_way    = WAY_IDX_W'(hit_way_reg);
    assign scan.free_found = free_found_reg;
    assign scan.free_way   = WAY_IDX_W'(free_way_reg);
    assign scan.lru_way    = WAY_IDX_W'(lru_way_reg);

endmodule

// ===== rtl/core/msc_update.sv =====
// Coherence and LRU update of one set row, and the response flags it produces.
module msc_update import msc_pkg::*; #(
    parameter int NUM_WAYS = 4,
    parameter int TAG_W    = 20,
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
    input  logic [CMD_W-1:0]   cmd,
    input  logic [TAG_W-1:0]   tag,
    input  logic               use_upgrade,
    input  scan_t              scan,
    input  logic [STATE_W-1:0] state_in  [NUM_WAYS],
    input  logic [TAG_W-1:0]   tag_in    [NUM_WAYS],
    input  logic [WAY_W-1:0]   rank_in   [NUM_WAYS],
    output logic [STATE_W-1:0] state_out [NUM_WAYS],
    output logic [TAG_W-1:0]   tag_out   [NUM_WAYS],
    output logic [WAY_W-1:0]   rank_out  [NUM_WAYS],
    output rsp_t               rsp
);

    logic [WAY_W-1:0]   tgt;
    logic [STATE_W-1:0] st;
    logic [WAY_W-1:0]   tgt_rank;
    logic               is_write;

    // Target way: the hit way, else the first free way, else the LRU way.
    assign tgt = scan.found      ? scan.hit_way[WAY_W-1:0]  :
                 scan.free_found ? scan.free_way[WAY_W-1:0] :
                                   scan.lru_way[WAY_W-1:0];
    assign st       = state_in[tgt];
    assign tgt_rank = rank_in[tgt];
    assign is_write = (cmd == CMD_PROC_WR);

    // Row update per command.
    always_comb
    begin
        state_out = state_in;
        tag_out   = tag_in;
        rank_out  = rank_in;
        rsp       = '0;
        unique case (cmd)
            CMD_PROC_RD, CMD_PROC_WR:
            begin
                // Move the target way to most recent; ways ranked more recent than it age by one.
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    if (WAY_W'(w) == tgt)
                    begin
                        rank_out[w] = '0;
                    end
                    else if (rank_in[w] < tgt_rank)
                    begin
                        rank_out[w] = rank_in[w] + 1'b1;
                    end
                end
                if (!scan.found)
                begin
                    rsp.write_back  = (st == ST_MODIFIED);
                    tag_out[tgt]    = tag;
                    state_out[tgt]  = is_write ? ST_MODIFIED : ST_SHARED;
                    rsp.bus_request = is_write ? REQ_BUSRDX : REQ_BUSRD;
                end
                else
                begin
                    rsp.hit = 1'b1;
                    if (is_write && (st == ST_SHARED))
                    begin
                        state_out[tgt]  = ST_MODIFIED;
                        rsp.bus_request = use_upgrade ? REQ_BUSUPGR : REQ_BUSRDX;
                    end
                end
            end
            CMD_SNP_RD:
            begin
                if (scan.found)
                begin
                    rsp.hit = 1'b1;
                    if (st == ST_MODIFIED)
                    begin
                        state_out[tgt]   = ST_SHARED;
                        rsp.flush_out    = 1'b1;
                        rsp.intervention = 1'b1;
                    end
                end
            end
            CMD_SNP_RDX, CMD_SNP_UPGR:
            begin
                if (scan.found)
                begin
                    rsp.hit         = 1'b1;
                    rsp.flush_out   = (cmd == CMD_SNP_RDX) && (st == ST_MODIFIED);
                    state_out[tgt]  = ST_INVALID;
                    rsp.invalidated = 1'b1;
                end
            end
            default:
            begin
                // Unused command codes leave the row alone and report nothing.
            end
        endcase
    end

endmodule

// ===== rtl/core/msi_snooping_cache_controller.sv =====
// Top level of the MSI snooping cache tag store with true LRU replacement.
//
//  Channel  Dir  Payload                                          Handshake
//  req      in   cmd, addr                                        valid/ready
//  rsp      out  bus_request, hit, write_back, flush_out,         valid/ready
//                invalidated, intervention
//  cfg      in   use_upgrade                                      valid/ready
//
// Each request passes through a set read from the tag RAM, a step per way through the
// shared way comparator, and a write of the row back to the tag RAM.
// After reset a clearing pass writes every set, with req.ready low.
// The response register lets the next request start while a response waits; the
// row write stalls only while a previous response is still not taken.
// cfg is always ready; a taken use_upgrade value applies to every row update after it.
module msi_snooping_cache_controller import msc_pkg::*; #(
    parameter int NUM_SETS   = 64,
    parameter int NUM_WAYS   = 4,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_BITS  = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    msc_req_if.sink   req,
    msc_rsp_if.source rsp,
    msc_cfg_if.sink   cfg
);

    localparam int WAY_W      = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int SET_BITS   = $clog2(NUM_SETS);
    localparam int IDX_W      = (NUM_SETS > 1) ? SET_BITS : 1;
    localparam int OFF_BITS   = $clog2(LINE_BYTES);
    localparam int EFF_ADDR_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int TAG_RAW    = EFF_ADDR_W - OFF_BITS - SET_BITS;
    localparam int TAG_W      = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int ENTRY_W    = STATE_W + TAG_W + WAY_W;
    localparam int ROW_W      = NUM_WAYS * ENTRY_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - EFF_ADDR_W);

    fsm_state_t         fsm_reg, fsm_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [WAY_W-1:0]   way_reg, way_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [IDX_W-1:0]   set_reg, set_next;
    logic               use_upgrade_reg;
    logic               out_valid_reg, out_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic [ADDR_W-1:0]  masked_addr;
    logic [ADDR_W-1:0]  blk_addr;
    logic [ADDR_W-1:0]  tag_addr;
    logic [IDX_W-1:0]   req_set;
    logic [TAG_W-1:0]   req_tag;
    logic               accept_in;
    logic               load_out;
    logic               scan_start;
    logic               scan_step;

    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [ROW_W-1:0]   ram_wr_data;
    logic [ROW_W-1:0]   ram_rd_data;
    logic [ROW_W-1:0]   clear_row;
    logic [ROW_W-1:0]   upd_row;

    logic [STATE_W-1:0] row_state [NUM_WAYS];
    logic [TAG_W-1:0]   row_tag   [NUM_WAYS];
    logic [WAY_W-1:0]   row_rank  [NUM_WAYS];
    logic [STATE_W-1:0] upd_state [NUM_WAYS];
    logic [TAG_W-1:0]   upd_tag   [NUM_WAYS];
    logic [WAY_W-1:0]   upd_rank  [NUM_WAYS];
    scan_t              scan;
    rsp_t               upd_rsp;

    // Address split into set index and tag.
    assign masked_addr = req.addr & ADDR_MASK;
    assign blk_addr    = masked_addr >> OFF_BITS;
    assign tag_addr    = blk_addr >> SET_BITS;
    assign req_set     = (SET_BITS == 0) ? '0 : blk_addr[IDX_W-1:0];
    assign req_tag     = tag_addr[TAG_W-1:0];

    assign accept_in = req.valid && req.ready;
    assign req.ready = (fsm_reg == FSM_IDLE);

    // Row unpacking, row packing and the reset row.
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            row_rank[w]  = ram_rd_data[w*ENTRY_W +: WAY_W];
            row_tag[w]   = ram_rd_data[w*ENTRY_W + WAY_W +: TAG_W];
            row_state[w] = ram_rd_data[w*ENTRY_W + WAY_W + TAG_W +: STATE_W];
            upd_row[w*ENTRY_W +: ENTRY_W]   = {upd_state[w], upd_tag[w], upd_rank[w]};
            clear_row[w*ENTRY_W +: ENTRY_W] = {STATE_W'(ST_INVALID), {TAG_W{1'b0}},
                                               WAY_W'(w)};
        end
    end

    // Tag store: one row holds every way of a set.
    msc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept_in),
        .rd_addr (req_set),
        .rd_data (ram_rd_data)
    );

    // Shared way comparator, stepped across the ways of the set.
    msc_way_unit #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_W    (TAG_W)
    ) u_way_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .step       (scan_step),
        .way        (way_reg),
        .way_state  (row_state[way_reg]),
        .way_tag    (row_tag[way_reg]),
        .way_rank   (row_rank[way_reg]),
        .lookup_tag (tag_reg),
        .scan       (scan)
    );

    // Coherence and LRU update of the scanned row.
    msc_update #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_W    (TAG_W)
    ) u_update (
        .cmd         (cmd_reg),
        .tag         (tag_reg),
        .use_upgrade (use_upgrade_reg),
        .scan        (scan),
        .state_in    (row_state),
        .tag_in      (row_tag),
        .rank_in     (row_rank),
        .state_out   (upd_state),
        .tag_out     (upd_tag),
        .rank_out    (upd_rank),
        .rsp         (upd_rsp)
    );

    // Sequencer: clearing pass, accept, way scan, row write-back.
    always_comb
    begin
        fsm_next    = fsm_reg;
        clr_next    = clr_reg;
        way_next    = way_reg;
        cmd_next    = cmd_reg;
        tag_next    = tag_reg;
        set_next    = set_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = set_reg;
        ram_wr_data = upd_row;
        scan_start  = 1'b0;
        scan_step   = 1'b0;
        load_out    = 1'b0;
        unique case (fsm_reg)
            FSM_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = clear_row;
                if (clr_reg == IDX_W'(NUM_SETS - 1))
                begin
                    fsm_next = FSM_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            FSM_IDLE:
            begin
                if (accept_in)
                begin
                    cmd_next   = req.cmd;
                    tag_next   = req_tag;
                    set_next   = req_set;
                    way_next   = '0;
                    scan_start = 1'b1;
                    fsm_next   = FSM_SCAN;
                end
            end
            FSM_SCAN:
            begin
                scan_step = 1'b1;
                if (way_reg == WAY_W'(NUM_WAYS - 1))
                begin
                    fsm_next = FSM_UPDATE;
                end
                else
                begin
                    way_next = way_reg + 1'b1;
                end
            end
            FSM_UPDATE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    ram_wr_en = 1'b1;
                    load_out  = 1'b1;
                    fsm_next  = FSM_IDLE;
                end
            end
            default:
            begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    // Response register.
    assign out_valid_next = load_out || (out_valid_reg && !rsp.ready);
    assign rsp_next       = load_out ? upd_rsp : rsp_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg         <= FSM_CLEAR;
            clr_reg         <= '0;
            way_reg         <= '0;
            out_valid_reg   <= 1'b0;
            use_upgrade_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            clr_reg       <= clr_next;
            way_reg       <= way_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                use_upgrade_reg <= cfg.use_upgrade;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        tag_reg <= tag_next;
        set_reg <= set_next;
        rsp_reg <= rsp_next;
    end

    // Port drive.
    assign cfg.ready        = 1'b1;
    assign rsp.valid        = out_valid_reg;
    assign rsp.bus_request  = rsp_reg.bus_request;
    assign rsp.hit          = rsp_reg.hit;
    assign rsp.write_back   = rsp_reg.write_back;
    assign rsp.flush_out    = rsp_reg.flush_out;
    assign rsp.invalidated  = rsp_reg.invalidated;
    assign rsp.intervention = rsp_reg.intervention;

endmodule

// ===== rtl/core/msc_checker.sv =====
// Port-level assertions for the cache controller, bound to the top level.
module msc_checker import msc_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [BUS_REQ_W-1:0] bus_request,
    input logic                 hit,
    input logic                 write_back,
    input logic                 flush_out,
    input logic                 invalidated,
    input logic                 intervention
);

    // The sequencer is busy in the cycle after it takes a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while the previous one is still in work");

    // A stalled response holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(bus_request) && $stable(hit)
            && $stable(write_back) && $stable(flush_out) && $stable(invalidated)
            && $stable(intervention))
        else $error("stalled response changed");

    // Processor bus requests never come with snoop flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (bus_request != REQ_NONE) |-> !flush_out && !invalidated && !intervention)
        else $error("bus request mixed with snoop outcome");

    // An intervention is a flush of a line that was present.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && intervention |-> flush_out && hit && !invalidated)
        else $error("intervention without flush of a present line");

    // A writeback only comes from a miss fill.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && write_back |-> !hit && ((bus_request == REQ_BUSRD)
            || (bus_request == REQ_BUSRDX)))
        else $error("writeback without a fill");

endmodule

bind msi_snooping_cache_controller msc_checker u_msc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .bus_request  (rsp.bus_request),
    .hit          (rsp.hit),
    .write_back   (rsp.write_back),
    .flush_out    (rsp.flush_out),
    .invalidated  (rsp.invalidated),
    .intervention (rsp.intervention)
);
